[rtl/core/sinetr_pkg.sv]
package sinetr_pkg;

  localparam int unsigned MaxTermsDef      = 16;
  localparam int unsigned AngleFracBitsDef = 28;

  localparam int unsigned AngleW   = 32;
  localparam int unsigned OutW     = 32;
  localparam int unsigned CfgW     = 5;
  localparam logic [CfgW-1:0] CfgReset = 5'd10;

  localparam int unsigned TermFrac = 40;
  localparam int unsigned OutFrac  = 24;
  localparam int unsigned OutDrop  = TermFrac - OutFrac;

  // Term magnitudes are 47 bits; the sum of up to 32 of them fits in 53 signed bits.
  localparam int unsigned MagW = 47;
  localparam int unsigned SumW = MagW + 6;

  typedef struct packed {
    logic                   neg_x;
    logic [CfgW-1:0]        n;
    logic [MagW-1:0]        x2;
    logic [MagW-1:0]        t;
    logic signed [SumW-1:0] sum;
  } term_bus_t;

endpackage

[rtl/core/sine_taylor_recurrence.sv]
// Channel   Direction  Handshake                   Payload
// input     in         in_valid_i / in_stall_o     angle_i (Q4.28)
// output    out        out_valid_o / out_stall_i   sine_value_o (Q8.24), saturated_o
// config    in         cfg_we_i                    cfg_wdata_i (term count)
//
// One item is accepted per cycle while in_stall_o is low. The path to out_valid_o
// runs through one squaring multiplier and two multipliers per term, each two
// register stages deep, plus the summing and output stages.
// A two-entry output buffer keeps taking items while a result waits; the whole
// pipeline holds only when that buffer is full. Reset empties the pipeline and
// sets the term count to 10.
module sine_taylor_recurrence import sinetr_pkg::*; #(
  parameter int unsigned MAX_TERMS       = MaxTermsDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [AngleW-1:0] angle_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [OutW-1:0]   sine_value_o,
  output logic              saturated_o
);

  logic [CfgW-1:0] term_count_q;
  logic            en;
  logic            valid [MAX_TERMS];
  term_bus_t       bus [MAX_TERMS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= CfgReset;
    end else if (cfg_we_i) begin
      term_count_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = !en;

  sinetr_front #(
    .MAX_TERMS       (MAX_TERMS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (in_valid_i),
    .angle_i      (angle_i),
    .term_count_i (term_count_q),
    .valid_o      (valid[0]),
    .bus_o        (bus[0])
  );

  for (genvar k = 1; k < MAX_TERMS; k++) begin : g_term
    sinetr_term #(
      .K (k)
    ) u_term (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (valid[k-1]),
      .bus_i   (bus[k-1]),
      .valid_o (valid[k]),
      .bus_o   (bus[k])
    );
  end

  sinetr_out #(
    .K (MAX_TERMS)
  ) u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid[MAX_TERMS-1]),
    .bus_i        (bus[MAX_TERMS-1]),
    .en_o         (en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .sine_value_o (sine_value_o),
    .saturated_o  (saturated_o)
  );

endmodule

[rtl/core/sinetr_mul.sv]
module sinetr_mul import sinetr_pkg::*; (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [MagW-1:0] a_i,
  input  logic [MagW-1:0] b_i,
  output logic [MagW-1:0] p_o
);

  localparam int unsigned LoW  = 24;
  localparam int unsigned HiW  = MagW - LoW;
  localparam int unsigned MidW = 2 * LoW;
  localparam int unsigned S1W  = MidW + 1;
  localparam int unsigned RW   = 2 * HiW + 8 + 1;

  logic [2*LoW-1:0]   ll_q;
  logic [LoW+HiW-1:0] lh_q;
  logic [LoW+HiW-1:0] hl_q;
  logic [2*HiW-1:0]   hh_q;
  logic [MagW-1:0]    p_q;

  logic [MidW-1:0] mid;
  logic [S1W-1:0]  s1;
  logic [RW-1:0]   r;
  logic [MagW-1:0] p_d;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= a_i[LoW-1:0] * b_i[LoW-1:0];
      lh_q <= a_i[LoW-1:0] * b_i[MagW-1:LoW];
      hl_q <= a_i[MagW-1:LoW] * b_i[LoW-1:0];
      hh_q <= a_i[MagW-1:LoW] * b_i[MagW-1:LoW];
    end
  end

  always_comb begin
    mid = MidW'(lh_q) + MidW'(hl_q);
    s1  = S1W'(ll_q[2*LoW-1:LoW]) + S1W'(mid);
    r   = RW'({hh_q, 8'b0}) + RW'(s1[S1W-1:16]);
    if (|r[RW-1:MagW]) begin
      p_d = {MagW{1'b1}};
    end else begin
      p_d = r[MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

[rtl/core/sinetr_front.sv]
module sinetr_front import sinetr_pkg::*; #(
  parameter int unsigned MAX_TERMS       = MaxTermsDef,
  parameter int unsigned ANGLE_FRAC_BITS = AngleFracBitsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [AngleW-1:0] angle_i,
  input  logic [CfgW-1:0]   term_count_i,
  output logic              valid_o,
  output term_bus_t         bus_o
);

  localparam int unsigned Shift = TermFrac - ANGLE_FRAC_BITS;
  localparam int unsigned XW    = AngleW + TermFrac - 16;

  logic [AngleW-1:0] amag;
  logic [XW-1:0]     xw;
  logic [MagW-1:0]   xm_d;
  logic [CfgW-1:0]   n_d;
  logic [MagW-1:0]   x2;

  logic [2:0]      valid_q;
  logic [2:0]      neg_q;
  logic [CfgW-1:0] n_q [3];
  logic [MagW-1:0] xm_q [3];

  always_comb begin
    amag = angle_i[AngleW-1] ? (~angle_i + AngleW'(1)) : angle_i;
    xw   = XW'(amag) << Shift;
    if (|xw[XW-1:MagW]) begin
      xm_d = {MagW{1'b1}};
    end else begin
      xm_d = xw[MagW-1:0];
    end
    if ({1'b0, term_count_i} > (CfgW+1)'(MAX_TERMS)) begin
      n_d = CfgW'(MAX_TERMS);
    end else begin
      n_d = term_count_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q   <= {neg_q[1:0], angle_i[AngleW-1]};
      n_q[0]  <= n_d;
      n_q[1]  <= n_q[0];
      n_q[2]  <= n_q[1];
      xm_q[0] <= xm_d;
      xm_q[1] <= xm_q[0];
      xm_q[2] <= xm_q[1];
    end
  end

  sinetr_mul u_sq (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (xm_q[0]),
    .b_i   (xm_q[0]),
    .p_o   (x2)
  );

  assign valid_o = valid_q[2];

  always_comb begin
    bus_o.neg_x = neg_q[2];
    bus_o.n     = n_q[2];
    bus_o.x2    = x2;
    bus_o.t     = xm_q[2];
    bus_o.sum   = '0;
  end

endmodule

[rtl/core/sinetr_term.sv]
module sinetr_term import sinetr_pkg::*; #(
  parameter int unsigned K = 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      valid_i,
  input  term_bus_t bus_i,
  output logic      valid_o,
  output term_bus_t bus_o
);

  localparam logic [63:0] Den   = 64'(2 * K * (2 * K + 1));
  localparam logic [63:0] Recip = ((64'd1 << TermFrac) + Den / 2) / Den;
  localparam logic [MagW-1:0] RecipMag = Recip[MagW-1:0];
  localparam bit KEven = (K % 2) == 0;

  logic                   neg_t;
  logic                   add_en;
  logic signed [SumW-1:0] t_ext;
  term_bus_t              bus_d;
  logic [MagW-1:0]        p1;
  logic [MagW-1:0]        p2;

  logic [3:0] valid_q;
  term_bus_t  bus_q [4];

  always_comb begin
    neg_t  = bus_i.neg_x ^ KEven;
    add_en = (CfgW+1)'(K) <= {1'b0, bus_i.n};
    t_ext  = {{(SumW-MagW){1'b0}}, bus_i.t};
    bus_d  = bus_i;
    if (add_en) begin
      bus_d.sum = neg_t ? (bus_i.sum - t_ext) : (bus_i.sum + t_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bus_q[0] <= bus_d;
      bus_q[1] <= bus_q[0];
      bus_q[2] <= bus_q[1];
      bus_q[3] <= bus_q[2];
    end
  end

  sinetr_mul u_mul_x2 (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (bus_i.t),
    .b_i   (bus_i.x2),
    .p_o   (p1)
  );

  sinetr_mul u_mul_recip (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (p1),
    .b_i   (RecipMag),
    .p_o   (p2)
  );

  assign valid_o = valid_q[3];

  always_comb begin
    bus_o   = bus_q[3];
    bus_o.t = p2;
  end

endmodule

[rtl/core/sinetr_out.sv]
module sinetr_out import sinetr_pkg::*; #(
  parameter int unsigned K = MaxTermsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  term_bus_t       bus_i,
  output logic            en_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [OutW-1:0] sine_value_o,
  output logic            saturated_o
);

  localparam bit KEven = (K % 2) == 0;
  localparam int unsigned QW = SumW - OutDrop;

  logic                   en;
  logic                   neg_t;
  logic                   add_en;
  logic signed [SumW-1:0] t_ext;
  logic signed [SumW-1:0] sum_d;

  logic                   valid_a_q;
  logic signed [SumW-1:0] sum_a_q;

  logic            neg_s;
  logic [SumW-1:0] smag;
  logic [QW-1:0]   q;
  logic [OutW-1:0] val;
  logic            sat;

  logic            push;
  logic            pop;
  logic [1:0]      count_q;
  logic [1:0]      count_d;
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [OutW-1:0] val_mem_q [2];
  logic            sat_mem_q [2];

  assign en = count_q != 2'd2;

  always_comb begin
    neg_t  = bus_i.neg_x ^ KEven;
    add_en = (CfgW+1)'(K) <= {1'b0, bus_i.n};
    t_ext  = {{(SumW-MagW){1'b0}}, bus_i.t};
    sum_d  = bus_i.sum;
    if (add_en) begin
      sum_d = neg_t ? (bus_i.sum - t_ext) : (bus_i.sum + t_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum_a_q <= sum_d;
    end
  end

  always_comb begin
    neg_s = sum_a_q[SumW-1];
    smag  = neg_s ? (~sum_a_q + SumW'(1)) : sum_a_q;
    q     = smag[SumW-1:OutDrop];
    sat   = 1'b0;
    if (!neg_s) begin
      if (q > QW'(32'h7FFF_FFFF)) begin
        val = 32'h7FFF_FFFF;
        sat = 1'b1;
      end else begin
        val = q[OutW-1:0];
      end
    end else begin
      if (q > QW'(32'h8000_0000)) begin
        val = 32'h8000_0000;
        sat = 1'b1;
      end else begin
        val = ~q[OutW-1:0] + OutW'(1);
      end
    end
  end

  assign push = en && valid_a_q;
  assign pop  = out_valid_o && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      val_mem_q[wr_ptr_q] <= val;
      sat_mem_q[wr_ptr_q] <= sat;
    end
  end

  assign en_o         = en;
  assign out_valid_o  = count_q != 2'd0;
  assign sine_value_o = val_mem_q[rd_ptr_q];
  assign saturated_o  = sat_mem_q[rd_ptr_q];

endmodule
